// ===== sv/missing_tooth_crank_pulse_generator_core_defines.svh =====
// Assertion macros shared by the crank pulse generator checker.
`ifndef MISSING_TOOTH_CRANK_PULSE_GENERATOR_CORE_DEFINES_SVH
`define MISSING_TOOTH_CRANK_PULSE_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define MTCP_ASSERT_IMPLY(name, clk_s, rstn_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MTCP_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mtcp_pkg.sv =====
// Shared widths, constants and interface structs of the crank pulse generator.
package mtcp_pkg;

  // Field widths
  localparam int KNOB_W     = 10;
  localparam int SPEED_W    = 14;
  localparam int HIGH_W     = 12;
  localparam int LOW_W      = 14;
  localparam int ELAPSED_W  = 14;
  localparam int SLOT_IDX_W = 4;
  localparam int IDX_W      = 7;

  // Wheel layout defaults
  localparam int SLOTS_PER_REV_DEF = 12;
  localparam int TOOTH_SLOTS_DEF   = 9;

  // Speed scaling: rpm = (knob * KNOB_GAIN / KNOB_FULL + SPEED_OFS) * SPEED_STEP
  localparam int KNOB_GAIN  = 96;
  localparam int KNOB_FULL  = 1023;
  localparam int SPEED_OFS  = 3;
  localparam int SPEED_STEP = 100;
  localparam int SPEED_MIN  = SPEED_OFS * SPEED_STEP;
  localparam int SPEED_MAX  = (KNOB_GAIN + SPEED_OFS) * SPEED_STEP;

  // Width numerators in microseconds
  localparam int HIGH_NUM = 10000000 / 12;
  localparam int LOW_NUM  = 5000000;

  // Reset values
  localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(1700);
  localparam logic [HIGH_W-1:0]  HIGH_RESET  = HIGH_W'(490);
  localparam logic [LOW_W-1:0]   LOW_RESET   = LOW_W'(2451);

  // Serial divider sizes
  localparam int DVD_W     = 23;
  localparam int DVS_W     = 14;
  localparam int DIV_CNT_W = $clog2(DVD_W);

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_cmd_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_sts_t;

  typedef struct packed {
    logic              tick;
    logic              knob;
    logic              load;
    logic [HIGH_W-1:0] high_width;
    logic [LOW_W-1:0]  low_width;
  } wheel_cmd_t;

  typedef struct packed {
    logic                  level;
    logic [SLOT_IDX_W-1:0] slot;
    logic                  tick_level;
    logic [SLOT_IDX_W-1:0] tick_slot;
  } wheel_sts_t;

endpackage

// ===== sv/mtcp_serial_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module mtcp_serial_div (
  input  logic                clk,
  input  logic                rst_n,
  input  mtcp_pkg::div_cmd_t  cmd,
  output mtcp_pkg::div_sts_t  sts
);
  import mtcp_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0]     quo_r, quo_nxt;
  logic [DVS_W-1:0]     rem_r, rem_nxt;
  logic [DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [DVS_W:0]       shifted;
  logic [DVS_W+1:0]     diff;
  logic                 ge;

  // Shift in the next dividend bit and trial-subtract the divisor
  always_comb begin
    shifted = {rem_r, quo_r[DVD_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_r};
    ge      = ~diff[DVS_W+1];
  end

  // Load on start, then step once per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = cmd.dividend;
      rem_nxt  = '0;
      dvs_nxt  = cmd.divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      rem_nxt = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign sts.done     = done_r;
  assign sts.quotient = quo_r;

endmodule

// ===== sv/mtcp_wheel.sv =====
// Tooth timing: phase, elapsed count, slot counter and pin level.
module mtcp_wheel #(
  parameter int SLOTS_PER_REV = mtcp_pkg::SLOTS_PER_REV_DEF,
  parameter int TOOTH_SLOTS   = mtcp_pkg::TOOTH_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mtcp_pkg::wheel_cmd_t cmd,
  output mtcp_pkg::wheel_sts_t sts
);
  import mtcp_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS_PER_REV);

  logic                 in_low_r, in_low_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic                 pin_r, pin_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [HIGH_W-1:0]    high_width_r, high_width_nxt;
  logic [LOW_W-1:0]     low_width_r, low_width_nxt;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic                 tooth;

  // Advance the phase on a tick, drop the pin on a knob request, take new widths on a load
  always_comb begin
    elapsed_inc    = elapsed_r + 1'b1;
    tooth          = {1'b0, slot_r} < (SLOT_W + 1)'(TOOTH_SLOTS);
    in_low_nxt     = in_low_r;
    elapsed_nxt    = elapsed_r;
    pin_nxt        = pin_r;
    slot_nxt       = slot_r;
    high_width_nxt = high_width_r;
    low_width_nxt  = low_width_r;
    if (cmd.tick) begin
      if (!in_low_r) begin
        if (elapsed_r == '0) begin
          pin_nxt = tooth;
        end
        if (elapsed_inc >= ELAPSED_W'(high_width_r)) begin
          in_low_nxt  = 1'b1;
          elapsed_nxt = '0;
        end else begin
          elapsed_nxt = elapsed_inc;
        end
      end else begin
        pin_nxt = 1'b0;
        if (elapsed_inc >= ELAPSED_W'(low_width_r)) begin
          in_low_nxt  = 1'b0;
          elapsed_nxt = '0;
          if (slot_r == SLOT_W'(SLOTS_PER_REV - 1)) begin
            slot_nxt = '0;
          end else begin
            slot_nxt = slot_r + 1'b1;
          end
        end else begin
          elapsed_nxt = elapsed_inc;
        end
      end
    end else if (cmd.knob) begin
      pin_nxt = 1'b0;
    end
    if (cmd.load) begin
      high_width_nxt = cmd.high_width;
      low_width_nxt  = cmd.low_width;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_low_r     <= 1'b0;
      elapsed_r    <= '0;
      pin_r        <= 1'b0;
      slot_r       <= '0;
      high_width_r <= HIGH_RESET;
      low_width_r  <= LOW_RESET;
    end else begin
      in_low_r     <= in_low_nxt;
      elapsed_r    <= elapsed_nxt;
      pin_r        <= pin_nxt;
      slot_r       <= slot_nxt;
      high_width_r <= high_width_nxt;
      low_width_r  <= low_width_nxt;
    end
  end

  // Current and post-tick view for the result register
  assign sts.level      = pin_r;
  assign sts.slot       = SLOT_IDX_W'(slot_r);
  assign sts.tick_level = pin_nxt;
  assign sts.tick_slot  = SLOT_IDX_W'(slot_nxt);

endmodule

// ===== sv/missing_tooth_crank_pulse_generator_core.sv =====
// Top level of the missing-tooth crank pulse generator.
//
//   Channel | Ports                                    | Direction
//   --------+------------------------------------------+----------
//   in      | in_valid, in_stall, in_mode,             | request in
//           | in_knob_value                            |
//   out     | out_valid, out_stall, out_crank_level,   | result out
//           | out_slot_index, out_engine_speed         |
//
// A tick request's result is registered at the same edge that accepts it.
// A knob request runs three passes of the one-bit-per-cycle divider (start,
// 23 steps, done), then the commit state: its result loads once the result
// register is free, and the input stalls until then.
// Reset (rst_n low, synchronous) restores 1700 rpm, slot 0 and a low pin.
// A knob request is taken while an earlier result waits; ticks and the commit
// wait until the result register is free.
module missing_tooth_crank_pulse_generator_core #(
  parameter int SLOTS_PER_REV = mtcp_pkg::SLOTS_PER_REV_DEF,
  parameter int TOOTH_SLOTS   = mtcp_pkg::TOOTH_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_mode,
  input  logic [mtcp_pkg::KNOB_W-1:0]       in_knob_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_crank_level,
  output logic [mtcp_pkg::SLOT_IDX_W-1:0]   out_slot_index,
  output logic [mtcp_pkg::SPEED_W-1:0]      out_engine_speed
);
  import mtcp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPEED,
    ST_HIGH,
    ST_LOW,
    ST_COMMIT
  } ctl_state_t;

  ctl_state_t            state_r, state_nxt;
  logic                  div_start_r, div_start_nxt;
  logic [DVD_W-1:0]      div_dvd_r, div_dvd_nxt;
  logic [DVS_W-1:0]      div_dvs_r, div_dvs_nxt;
  logic [SPEED_W-1:0]    speed_r, speed_nxt;
  logic [SPEED_W-1:0]    rpm_tmp_r, rpm_tmp_nxt;
  logic [HIGH_W-1:0]     high_tmp_r, high_tmp_nxt;
  logic [LOW_W-1:0]      low_tmp_r, low_tmp_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_crank_r, out_crank_nxt;
  logic [SLOT_IDX_W-1:0] out_slot_r, out_slot_nxt;
  logic [SPEED_W-1:0]    out_speed_r, out_speed_nxt;

  logic                  out_free;
  logic                  tick_acc;
  logic                  knob_acc;
  logic [DVD_W-1:0]      knob_prod;
  logic [SPEED_W-1:0]    knob_rpm;
  logic [LOW_W-1:0]      low_calc;

  div_cmd_t              div_cmd;
  div_sts_t              div_sts;
  wheel_cmd_t            wheel_cmd;
  wheel_sts_t            wheel_sts;

  // Decode the input handshake
  always_comb begin
    out_free = !out_valid_r || !out_stall;
    in_stall = (state_r != ST_IDLE) || (!in_mode && !out_free);
    tick_acc = in_valid && !in_stall && !in_mode;
    knob_acc = in_valid && !in_stall && in_mode;
  end

  // Speed and width arithmetic around the divider
  always_comb begin
    knob_prod = DVD_W'(in_knob_value) * DVD_W'(KNOB_GAIN);
    knob_rpm  = SPEED_W'((int'(div_sts.quotient[IDX_W-1:0]) + SPEED_OFS) * SPEED_STEP);
    low_calc  = div_sts.quotient[LOW_W-1:0] - LOW_W'(high_tmp_r);
  end

  // Register tick results; sequence the three divisions and the commit
  always_comb begin
    state_nxt     = state_r;
    div_start_nxt = 1'b0;
    div_dvd_nxt   = div_dvd_r;
    div_dvs_nxt   = div_dvs_r;
    speed_nxt     = speed_r;
    rpm_tmp_nxt   = rpm_tmp_r;
    high_tmp_nxt  = high_tmp_r;
    low_tmp_nxt   = low_tmp_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_crank_nxt = out_crank_r;
    out_slot_nxt  = out_slot_r;
    out_speed_nxt = out_speed_r;
    unique case (state_r)
      ST_IDLE: begin
        if (knob_acc) begin
          div_start_nxt = 1'b1;
          div_dvd_nxt   = knob_prod;
          div_dvs_nxt   = DVS_W'(KNOB_FULL);
          state_nxt     = ST_SPEED;
        end else if (tick_acc) begin
          out_valid_nxt = 1'b1;
          out_crank_nxt = wheel_sts.tick_level;
          out_slot_nxt  = wheel_sts.tick_slot;
          out_speed_nxt = speed_r;
        end
      end
      ST_SPEED: begin
        if (div_sts.done) begin
          rpm_tmp_nxt   = knob_rpm;
          div_start_nxt = 1'b1;
          div_dvd_nxt   = DVD_W'(HIGH_NUM);
          div_dvs_nxt   = DVS_W'(knob_rpm);
          state_nxt     = ST_HIGH;
        end
      end
      ST_HIGH: begin
        if (div_sts.done) begin
          high_tmp_nxt  = div_sts.quotient[HIGH_W-1:0];
          div_start_nxt = 1'b1;
          div_dvd_nxt   = DVD_W'(LOW_NUM);
          div_dvs_nxt   = DVS_W'(rpm_tmp_r);
          state_nxt     = ST_LOW;
        end
      end
      ST_LOW: begin
        if (div_sts.done) begin
          low_tmp_nxt = low_calc;
          state_nxt   = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          speed_nxt     = rpm_tmp_r;
          out_valid_nxt = 1'b1;
          out_crank_nxt = wheel_sts.level;
          out_slot_nxt  = wheel_sts.slot;
          out_speed_nxt = rpm_tmp_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold sequencer state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_start_r <= 1'b0;
      speed_r     <= SPEED_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_start_r <= div_start_nxt;
      speed_r     <= speed_nxt;
      out_valid_r <= out_valid_nxt;
      div_dvd_r   <= div_dvd_nxt;
      div_dvs_r   <= div_dvs_nxt;
      rpm_tmp_r   <= rpm_tmp_nxt;
      high_tmp_r  <= high_tmp_nxt;
      low_tmp_r   <= low_tmp_nxt;
      out_crank_r <= out_crank_nxt;
      out_slot_r  <= out_slot_nxt;
      out_speed_r <= out_speed_nxt;
    end
  end

  assign div_cmd.start    = div_start_r;
  assign div_cmd.dividend = div_dvd_r;
  assign div_cmd.divisor  = div_dvs_r;

  assign wheel_cmd.tick       = tick_acc;
  assign wheel_cmd.knob       = knob_acc;
  assign wheel_cmd.load       = (state_r == ST_COMMIT) && out_free;
  assign wheel_cmd.high_width = high_tmp_r;
  assign wheel_cmd.low_width  = low_tmp_r;

  mtcp_serial_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (div_cmd),
    .sts   (div_sts)
  );

  mtcp_wheel #(
    .SLOTS_PER_REV (SLOTS_PER_REV),
    .TOOTH_SLOTS   (TOOTH_SLOTS)
  ) u_wheel (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (wheel_cmd),
    .sts   (wheel_sts)
  );

  assign out_valid        = out_valid_r;
  assign out_crank_level  = out_crank_r;
  assign out_slot_index   = out_slot_r;
  assign out_engine_speed = out_speed_r;

endmodule

// ===== sv/mtcp_checker.sv =====
// Port-level checks of the crank pulse generator, bound to the top level.
`include "missing_tooth_crank_pulse_generator_core_defines.svh"

module mtcp_checker #(
  parameter int SLOTS_PER_REV = mtcp_pkg::SLOTS_PER_REV_DEF,
  parameter int TOOTH_SLOTS   = mtcp_pkg::TOOTH_SLOTS_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            in_mode,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            out_crank_level,
  input logic [mtcp_pkg::SLOT_IDX_W-1:0] out_slot_index,
  input logic [mtcp_pkg::SPEED_W-1:0]    out_engine_speed
);
  import mtcp_pkg::*;

  // Hold a stalled result
  `MTCP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_crank_level) && $stable(out_slot_index) && $stable(out_engine_speed), "stalled result changed")

  // Deliver a tick result on the next cycle
  `MTCP_ASSERT_NEXT(a_tick_result, clk, rst_n, in_valid && !in_stall && !in_mode, out_valid, "tick request gave no result")

  // Keep the speed inside the knob range
  `MTCP_ASSERT_IMPLY(a_speed_range, clk, rst_n, out_valid, (int'(out_engine_speed) >= SPEED_MIN) && (int'(out_engine_speed) <= SPEED_MAX), "engine speed out of range")

  // Keep the slot inside the revolution
  `MTCP_ASSERT_IMPLY(a_slot_range, clk, rst_n, out_valid, int'(out_slot_index) < SLOTS_PER_REV, "slot index out of range")

  // Raise the pin only on a tooth slot
  `MTCP_ASSERT_IMPLY(a_tooth_only, clk, rst_n, out_valid && out_crank_level, int'(out_slot_index) < TOOTH_SLOTS, "pin high on a missing tooth")

endmodule

bind missing_tooth_crank_pulse_generator_core mtcp_checker #(
  .SLOTS_PER_REV (SLOTS_PER_REV),
  .TOOTH_SLOTS   (TOOTH_SLOTS)
) u_mtcp_checker (.*);

// ===== tb/sv/missing_tooth_crank_pulse_generator_core_test.sv =====
// Self-checking testbench for the missing-tooth crank pulse generator core.
`timescale 1ns / 1ps

module missing_tooth_crank_pulse_generator_core_test;
  import mtcp_pkg::*;

  localparam int WHEEL_SLOTS  = SLOTS_PER_REV_DEF;
  localparam int WHEEL_TEETH  = TOOTH_SLOTS_DEF;
  localparam int IDLE_MAX     = 14;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT_A    = 200;
  localparam int HOLD_AT_B    = 260;
  localparam int SEGMENTS     = 12;
  localparam int SETTLE_CYCLES = 120;
  // Worst case: every request pays a full idle gap, a full stall and a knob sequence, two holds; x5.
  localparam int CYCLE_LIMIT  = 250_000;

  typedef enum logic {
    MODE_TICK = 1'b0,
    MODE_KNOB = 1'b1
  } crank_mode_t;

  typedef struct {
    crank_mode_t       mode;
    logic [KNOB_W-1:0] knob;
    int                gap;
    bit                drain;
  } crank_req_t;

  typedef struct {
    logic                  level;
    logic [SLOT_IDX_W-1:0] slot;
    logic [SPEED_W-1:0]    speed;
  } crank_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_mode = MODE_TICK;
  logic [KNOB_W-1:0]     in_knob_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_crank_level;
  logic [SLOT_IDX_W-1:0] out_slot_index;
  logic [SPEED_W-1:0]    out_engine_speed;

  // Wheel state mirrored by the predictor
  logic [SPEED_W-1:0]    speed_rpm;
  logic [HIGH_W-1:0]     high_width;
  logic [LOW_W-1:0]      low_width;
  logic [SLOT_IDX_W-1:0] slot_now;
  logic                  low_phase;
  logic [ELAPSED_W-1:0]  elapsed;
  logic                  pin_level;

  crank_req_t    requests_to_send[$];
  crank_result_t wheel_outputs_due[$];
  crank_req_t    cur_req;

  int  reqs_taken = 0;
  int  results_cnt = 0;
  int  err_cnt = 0;
  int  tick_cnt = 0;
  int  knob_cnt = 0;
  int  rev_cnt = 0;
  int  cycle_cnt = 0;
  int  gap_left = 0;
  bit  gap_loaded = 1'b0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  int  rx_wait = 0;
  int  hold_left = 0;

  missing_tooth_crank_pulse_generator_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_knob_value    (in_knob_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_crank_level  (out_crank_level),
    .out_slot_index   (out_slot_index),
    .out_engine_speed (out_engine_speed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Restore the wheel to its power-up timing
  function automatic void wheel_reset();
    speed_rpm  = SPEED_RESET;
    high_width = HIGH_RESET;
    low_width  = LOW_RESET;
    slot_now   = '0;
    low_phase  = 1'b0;
    elapsed    = '0;
    pin_level  = 1'b0;
  endfunction

  // Advance the wheel by one request and return the pin, slot and speed after it
  function automatic crank_result_t wheel_step(crank_req_t req);
    crank_result_t res;
    int rpm;
    if (req.mode == MODE_KNOB) begin
      knob_cnt++;
      rpm = ((int'(req.knob) * KNOB_GAIN) / KNOB_FULL + SPEED_OFS) * SPEED_STEP;
      speed_rpm  = SPEED_W'(rpm);
      high_width = HIGH_W'(HIGH_NUM / rpm);
      low_width  = LOW_W'(LOW_NUM / rpm - HIGH_NUM / rpm);
      pin_level  = 1'b0;
    end else if (!low_phase) begin
      tick_cnt++;
      // tooth begins only on the first tick of a slot
      if (elapsed == 0) pin_level = (int'(slot_now) < WHEEL_TEETH);
      elapsed = elapsed + 1'b1;
      if (elapsed >= high_width) begin
        low_phase = 1'b1;
        elapsed   = '0;
      end
    end else begin
      tick_cnt++;
      pin_level = 1'b0;
      elapsed   = elapsed + 1'b1;
      if (elapsed >= low_width) begin
        low_phase = 1'b0;
        elapsed   = '0;
        if (int'(slot_now) + 1 >= WHEEL_SLOTS) begin
          slot_now = '0;
          rev_cnt++;
        end else begin
          slot_now = slot_now + 1'b1;
        end
      end
    end
    res.level = pin_level;
    res.slot  = slot_now;
    res.speed = speed_rpm;
    return res;
  endfunction

  // Queue one request with its idle gap
  function automatic void push_req(crank_mode_t mode, int knob, bit drain);
    crank_req_t r;
    r.mode  = mode;
    r.knob  = KNOB_W'(knob);
    r.gap   = tx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
    r.drain = drain;
    requests_to_send.push_back(r);
  endfunction

  // Favor fast wheels so that slots turn over, but keep the extremes and slow speeds
  function automatic int pick_knob();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return KNOB_FULL;
      2:       return $urandom_range(0, KNOB_FULL);
      default: return $urandom_range(800, KNOB_FULL);
    endcase
  endfunction

  // Present requests; predict each one as it is accepted
  always @(posedge clk) begin : drive_proc
    logic showing;
    crank_result_t due;
    if (!rst_n) begin
      in_valid      <= 1'b0;
      in_mode       <= MODE_TICK;
      in_knob_value <= '0;
      wheel_reset();
      gap_left   = 0;
      gap_loaded = 1'b0;
    end else begin
      showing = in_valid;
      if (in_valid && !in_stall) begin
        due = wheel_step(cur_req);
        wheel_outputs_due.push_back(due);
        reqs_taken = reqs_taken + 1;
        showing = 1'b0;
      end
      if (!showing && requests_to_send.size() > 0) begin
        if (!gap_loaded) begin
          gap_left   = requests_to_send[0].gap;
          gap_loaded = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
        end else if (!requests_to_send[0].drain || results_cnt == reqs_taken) begin
          cur_req       = requests_to_send.pop_front();
          gap_loaded    = 1'b0;
          showing       = 1'b1;
          in_mode       <= cur_req.mode;
          in_knob_value <= cur_req.knob;
        end
      end
      in_valid <= showing;
    end
  end

  // Take results, compare with the oldest prediction, and stall at random
  always @(posedge clk) begin : check_proc
    crank_result_t due;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait   = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (wheel_outputs_due.size() == 0) begin
          $error("result with no request waiting: level %0d slot %0d speed %0d",
                 out_crank_level, out_slot_index, out_engine_speed);
          err_cnt++;
        end else begin
          due = wheel_outputs_due.pop_front();
          if (out_crank_level !== due.level) begin
            $error("crank_level mismatch: expected %0d, actual %0d",
                   due.level, out_crank_level);
            err_cnt++;
          end
          if (out_slot_index !== due.slot) begin
            $error("slot_index mismatch: expected %0d, actual %0d",
                   due.slot, out_slot_index);
            err_cnt++;
          end
          if (out_engine_speed !== due.speed) begin
            $error("engine_speed mismatch: expected %0d, actual %0d",
                   due.speed, out_engine_speed);
            err_cnt++;
          end
        end
        results_cnt <= results_cnt + 1;
        if ((results_cnt + 1) % 97 == 0) rx_idle_on = ($urandom_range(0, 2) != 0);
        rx_wait = rx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
        // hold off long enough for the block to back up into its input
        if (results_cnt + 1 == HOLD_AT_A || results_cnt + 1 == HOLD_AT_B)
          hold_left = HOLD_CYCLES;
      end else if (hold_left > 0) begin
        hold_left--;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall <= (hold_left > 0) || (rx_wait > 0);
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stim_proc
    int n;
    int i;
    // Directed: tooth start, ignored knob bits on ticks, knob extremes and patterns
    push_req(MODE_TICK, KNOB_FULL, 1'b0);
    push_req(MODE_TICK, 'h155, 1'b0);
    push_req(MODE_TICK, 'h2AA, 1'b0);
    push_req(MODE_KNOB, KNOB_FULL, 1'b0);  // drop the pin mid-tooth
    push_req(MODE_TICK, 0, 1'b0);
    push_req(MODE_TICK, KNOB_FULL, 1'b0);
    push_req(MODE_KNOB, 0, 1'b0);
    push_req(MODE_TICK, 'h2AA, 1'b0);
    push_req(MODE_KNOB, 'h2AA, 1'b0);
    push_req(MODE_KNOB, 'h155, 1'b0);
    push_req(MODE_KNOB, 1, 1'b0);
    push_req(MODE_KNOB, 11, 1'b0);
    push_req(MODE_KNOB, 1022, 1'b0);
    push_req(MODE_KNOB, 512, 1'b0);
    push_req(MODE_TICK, 'h155, 1'b0);
    push_req(MODE_TICK, 0, 1'b0);
    push_req(MODE_KNOB, KNOB_FULL, 1'b1);
    push_req(MODE_TICK, 0, 1'b0);
    push_req(MODE_TICK, KNOB_FULL, 1'b0);

    // Slow wheel deep into a long tooth, then a fast wheel cuts the tooth short
    push_req(MODE_KNOB, 0, 1'b1);
    n = $urandom_range(90, 130);
    for (i = 0; i < n; i++) push_req(MODE_TICK, $urandom_range(0, KNOB_FULL), 1'b0);
    push_req(MODE_KNOB, KNOB_FULL, 1'b0);
    for (i = 0; i < 40; i++) push_req(MODE_TICK, $urandom_range(0, KNOB_FULL), 1'b0);

    // Random segments: a speed change, then a burst of ticks with rare knob changes
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      tx_idle_on = ($urandom_range(0, 2) != 0);
      push_req(MODE_KNOB, pick_knob(), seg == 0 || $urandom_range(0, 3) == 0);
      n = $urandom_range(10, 35);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 29) == 0)
          push_req(MODE_KNOB, $urandom_range(0, KNOB_FULL), 1'b0);
        else
          push_req(MODE_TICK, $urandom_range(0, KNOB_FULL), 1'b0);
      end
    end

    // Hold reset, then release
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every request to go in and every result to come back
    @(negedge clk);
    while (requests_to_send.size() > 0 || in_valid || results_cnt != reqs_taken)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (wheel_outputs_due.size() != 0) begin
      $error("%0d predicted results never arrived", wheel_outputs_due.size());
      err_cnt++;
    end

    $display("Sent %0d ticks and %0d speed changes; checked %0d results.",
             tick_cnt, knob_cnt, results_cnt);
    $display("Wheel completed %0d revolutions; %0d mismatches.", rev_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
